>>> rtl/avtc_pkg.sv
// Package for the audio/video timestamp corrector.
// Holds the field widths, packet kinds, register indexes, reset values and shared types.
// No dependencies.
package avtc_pkg;

    localparam int TIME_W     = 32;
    localparam int FIX_W      = 64;
    localparam int DELTA_W    = 16;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [KIND_W-1:0] KIND_VIDEO  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_AUDIO  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HEADER = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_VIDEO_DELTA     = 3'd0,
        CFG_DEFAULT_VIDEO_DELTA = 3'd1,
        CFG_MAX_AUDIO_DELTA     = 3'd2,
        CFG_DEFAULT_AUDIO_DELTA = 3'd3,
        CFG_AUDIO_FOLLOWS_VIDEO = 3'd4
    } t_cfg_idx;

    localparam logic [DELTA_W-1:0] RST_MAX_VIDEO_DELTA     = 16'd100;
    localparam logic [DELTA_W-1:0] RST_DEFAULT_VIDEO_DELTA = 16'd40;
    localparam logic [DELTA_W-1:0] RST_MAX_AUDIO_DELTA     = 16'd100;
    localparam logic [DELTA_W-1:0] RST_DEFAULT_AUDIO_DELTA = 16'd20;

    typedef struct packed {
        logic [DELTA_W-1:0] max_video_delta;
        logic [DELTA_W-1:0] default_video_delta;
        logic [DELTA_W-1:0] max_audio_delta;
        logic [DELTA_W-1:0] default_audio_delta;
        logic               audio_follows_video;
    } t_cfg;

    typedef struct packed {
        logic [FIX_W-1:0]   base_fixed;
        logic [TIME_W-1:0]  base_raw;
        logic [DELTA_W-1:0] limit;
        logic [DELTA_W-1:0] dflt;
    } t_adv_req;

    // Magnitude of the difference of two raw times, kept at full width.
    function automatic logic [TIME_W:0] abs_diff(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
        logic [TIME_W:0] d;
        begin
            d = {1'b0, a} - {1'b0, b};
            abs_diff = d[TIME_W] ? (~d + 1'b1) : d;
        end
    endfunction

endpackage

>>> rtl/avtc_in_if.sv
// Input channel of the timestamp corrector: one packet item per handshake.
// Depends on avtc_pkg for the field widths.
interface avtc_in_if;
    logic                         valid;
    logic                         ready;
    logic [avtc_pkg::KIND_W-1:0]  packet_kind;
    logic [avtc_pkg::TIME_W-1:0]  raw_time;

    modport source (output valid, output packet_kind, output raw_time, input ready);
    modport sink   (input valid, input packet_kind, input raw_time, output ready);
endinterface

>>> rtl/avtc_out_if.sv
// Result channel of the timestamp corrector: one corrected timestamp per item.
// Depends on avtc_pkg for the field width.
interface avtc_out_if;
    logic                         valid;
    logic                         ready;
    logic [avtc_pkg::TIME_W-1:0]  corrected_time;

    modport source (output valid, output corrected_time, input ready);
    modport sink   (input valid, input corrected_time, output ready);
endinterface

>>> rtl/avtc_cfg_regs.sv
// Configuration register bank of the timestamp corrector.
// Depends on avtc_pkg for register indexes, reset values and the t_cfg type.
module avtc_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [avtc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [avtc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output avtc_pkg::t_cfg                    o_cfg
);
    import avtc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_video_delta     <= RST_MAX_VIDEO_DELTA;
            r_cfg.default_video_delta <= RST_DEFAULT_VIDEO_DELTA;
            r_cfg.max_audio_delta     <= RST_MAX_AUDIO_DELTA;
            r_cfg.default_audio_delta <= RST_DEFAULT_AUDIO_DELTA;
            r_cfg.audio_follows_video <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_VIDEO_DELTA:     r_cfg.max_video_delta     <= i_cfg_data;
                CFG_DEFAULT_VIDEO_DELTA: r_cfg.default_video_delta <= i_cfg_data;
                CFG_MAX_AUDIO_DELTA:     r_cfg.max_audio_delta     <= i_cfg_data;
                CFG_DEFAULT_AUDIO_DELTA: r_cfg.default_audio_delta <= i_cfg_data;
                CFG_AUDIO_FOLLOWS_VIDEO: r_cfg.audio_follows_video <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/avtc_advance.sv
// Delta step of the timestamp corrector: base plus raw delta or default delta,
// clamped at zero. Depends on avtc_pkg for widths, t_adv_req and abs_diff.
module avtc_advance (
    input  avtc_pkg::t_adv_req               i_req,
    input  logic [avtc_pkg::TIME_W-1:0]      i_now,
    output logic [avtc_pkg::FIX_W-1:0]       o_fixed
);
    import avtc_pkg::*;

    localparam int STEP_W = DELTA_W + 1;

    logic [TIME_W:0]  diff;
    logic [TIME_W:0]  mag;
    logic             in_range;
    logic [STEP_W-1:0] step;
    logic [FIX_W-1:0] sum;

    always_comb begin
        diff     = {1'b0, i_now} - {1'b0, i_req.base_raw};
        mag      = abs_diff(i_now, i_req.base_raw);
        in_range = mag < {{(TIME_W + 1 - DELTA_W){1'b0}}, i_req.limit};
        // An in-range delta is below the 16-bit limit, so 17 signed bits hold it.
        step     = in_range ? diff[STEP_W-1:0] : {1'b0, i_req.dflt};
        sum      = i_req.base_fixed + {{(FIX_W - STEP_W){step[STEP_W-1]}}, step};
        o_fixed  = sum[FIX_W-1] ? '0 : sum;
    end

endmodule

>>> rtl/av_timestamp_corrector_core.sv
// Audio/video timestamp corrector, top level.
// An accepted item passes through the input register and then the result register to the output channel.
// Throughput: one packet item per cycle; the result register stalls only on output backpressure.
// The stream state is read from the input register and updated as the item enters the result register.
// Reset (synchronous, active low) clears the valid flags, seen flags and run count,
// and loads the configuration registers with their defaults.
module av_timestamp_corrector_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    avtc_in_if.sink                           i_pkt,
    avtc_out_if.source                        o_res,
    input  logic                              i_cfg_we,
    input  logic [avtc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [avtc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import avtc_pkg::*;

    localparam logic [1:0] RUN_MAX = 2'd3;

    t_cfg cfg;

    logic                r_in_valid;
    logic [KIND_W-1:0]   r_in_kind;
    logic [TIME_W-1:0]   r_in_time;
    logic                r_out_valid;
    logic [TIME_W-1:0]   r_out_time;

    logic                r_video_seen;
    logic [TIME_W-1:0]   r_video_raw;
    logic [FIX_W-1:0]    r_video_fixed;
    logic                r_audio_seen;
    logic [TIME_W-1:0]   r_audio_raw;
    logic [FIX_W-1:0]    r_audio_fixed;
    logic [1:0]          r_run_cnt;

    logic                n_video_seen;
    logic [TIME_W-1:0]   n_video_raw;
    logic [FIX_W-1:0]    n_video_fixed;
    logic                n_audio_seen;
    logic [TIME_W-1:0]   n_audio_raw;
    logic [FIX_W-1:0]    n_audio_fixed;
    logic [1:0]          n_run_cnt;
    logic [TIME_W-1:0]   n_out_time;

    logic                fire;
    logic                far_apart;
    logic                bypass;
    t_adv_req            adv_req;
    logic [FIX_W-1:0]    adv_fixed;

    avtc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    avtc_advance u_adv (
        .i_req   (adv_req),
        .i_now   (r_in_time),
        .o_fixed (adv_fixed)
    );

    assign fire         = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_pkt.ready  = !r_in_valid || fire;
    assign o_res.valid  = r_out_valid;
    assign o_res.corrected_time = r_out_time;

    assign far_apart = abs_diff(r_audio_raw, r_in_time) >=
                       {{(TIME_W + 1 - DELTA_W){1'b0}}, cfg.max_video_delta};

    // Operand selection for the delta step.
    always_comb begin
        adv_req.base_fixed = r_audio_fixed;
        adv_req.base_raw   = r_audio_raw;
        adv_req.limit      = cfg.max_audio_delta;
        adv_req.dflt       = cfg.default_audio_delta;
        bypass             = 1'b0;
        case (r_in_kind)
            KIND_VIDEO: begin
                adv_req.limit = cfg.max_video_delta;
                adv_req.dflt  = cfg.default_video_delta;
                if (r_video_seen) begin
                    adv_req.base_fixed = r_video_fixed;
                    adv_req.base_raw   = r_video_raw;
                end else if (!(r_audio_seen && far_apart)) begin
                    adv_req.base_fixed = {{(FIX_W - TIME_W){1'b0}}, r_in_time};
                    adv_req.base_raw   = r_in_time;
                end
            end
            KIND_AUDIO: begin
                if (cfg.audio_follows_video && (r_run_cnt == 2'd0)) begin
                    adv_req.base_fixed = r_video_fixed;
                    adv_req.base_raw   = r_video_raw;
                    adv_req.limit      = cfg.max_video_delta;
                    adv_req.dflt       = cfg.default_video_delta;
                    bypass             = !r_video_seen;
                end else begin
                    bypass = !r_audio_seen;
                end
            end
            default: ;
        endcase
    end

    // Next stream state and result.
    always_comb begin
        n_video_seen  = r_video_seen;
        n_video_raw   = r_video_raw;
        n_video_fixed = r_video_fixed;
        n_audio_seen  = r_audio_seen;
        n_audio_raw   = r_audio_raw;
        n_audio_fixed = r_audio_fixed;
        n_run_cnt     = r_run_cnt;
        n_out_time    = '0;
        case (r_in_kind)
            KIND_VIDEO: begin
                n_video_seen  = 1'b1;
                n_video_raw   = r_in_time;
                n_video_fixed = adv_fixed;
                n_run_cnt     = 2'd0;
                n_out_time    = adv_fixed[TIME_W-1:0];
            end
            KIND_AUDIO: begin
                if (cfg.audio_follows_video && (r_run_cnt != RUN_MAX)) begin
                    n_run_cnt = r_run_cnt + 2'd1;
                end
                n_audio_seen  = 1'b1;
                n_audio_raw   = r_in_time;
                n_audio_fixed = bypass ? {{(FIX_W - TIME_W){1'b0}}, r_in_time} : adv_fixed;
                n_out_time    = bypass ? r_in_time : adv_fixed[TIME_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_video_seen <= 1'b0;
            r_audio_seen <= 1'b0;
            r_run_cnt    <= 2'd0;
        end else begin
            if (i_pkt.ready) begin
                r_in_valid <= i_pkt.valid;
            end
            if (fire) begin
                r_out_valid  <= 1'b1;
                r_video_seen <= n_video_seen;
                r_audio_seen <= n_audio_seen;
                r_run_cnt    <= n_run_cnt;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pkt.valid && i_pkt.ready) begin
            r_in_kind <= i_pkt.packet_kind;
            r_in_time <= i_pkt.raw_time;
        end
        if (fire) begin
            r_video_raw   <= n_video_raw;
            r_video_fixed <= n_video_fixed;
            r_audio_raw   <= n_audio_raw;
            r_audio_fixed <= n_audio_fixed;
            r_out_time    <= n_out_time;
        end
    end

endmodule

>>> rtl/avtc_checker.sv
// Port-level checks for the timestamp corrector, attached to the top level by bind.
// Depends on avtc_pkg for the field width and on av_timestamp_corrector_core.
module avtc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [avtc_pkg::TIME_W-1:0]   i_out_time
);
    import avtc_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_time)))
        else $error("Stalled result changed or dropped.");

    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(in_acc, 2))
        else $error("Result appeared without an item accepted two cycles earlier.");

    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("Input stalled while the result side was free.");

    a_buffer_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready && in_acc) ##1 !i_out_ready |-> !i_in_ready)
        else $error("Input accepted beyond the two item stages.");

endmodule

bind av_timestamp_corrector_core avtc_checker u_avtc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pkt.valid),
    .i_in_ready  (i_pkt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_time  (o_res.corrected_time)
);
